>>> hdl/arcpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arcpi_pkg
// Shared types, codes and constant tables of the arc pose integrator.
// ----------------------------------------------------------------------------
package arcpi_pkg;

  // CORDIC: thirty micro-rotations on a 34-bit signed datapath
  localparam int CORDIC_STEPS = 30;
  localparam int CORD_W       = 34;
  localparam logic signed [CORD_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [CORD_W-1:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [CORD_W-1:0] HALF_TURN    = 34'sd2147483648;

  // 1/(2*pi) in Q0.32 turns per radian
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;

  // Local displacement magnitude limit, 2^33 - 1
  localparam logic [32:0] LOCAL_LIMIT = 33'h1_FFFF_FFFF;

  // Configuration register indexes
  localparam logic CFG_STEP_LENGTH    = 1'b0;
  localparam logic CFG_TURN_CURVATURE = 1'b1;

  // Motion codes
  localparam logic [2:0] MOT_NONE       = 3'd0;
  localparam logic [2:0] MOT_FWD        = 3'd1;
  localparam logic [2:0] MOT_FWD_LEFT   = 3'd2;
  localparam logic [2:0] MOT_FWD_RIGHT  = 3'd3;
  localparam logic [2:0] MOT_BACK       = 3'd4;
  localparam logic [2:0] MOT_BACK_LEFT  = 3'd5;
  localparam logic [2:0] MOT_BACK_RIGHT = 3'd6;

  // Datapath step codes
  localparam logic [3:0] DP_NOP       = 4'd0;
  localparam logic [3:0] DP_CAPTURE   = 4'd1;
  localparam logic [3:0] DP_MUL_P     = 4'd2;
  localparam logic [3:0] DP_MUL_HI    = 4'd3;
  localparam logic [3:0] DP_MUL_LO    = 4'd4;
  localparam logic [3:0] DP_PHI       = 4'd5;
  localparam logic [3:0] DP_START_PHI = 4'd6;
  localparam logic [3:0] DP_STORE_PHI = 4'd7;
  localparam logic [3:0] DP_LOCAL     = 4'd8;
  localparam logic [3:0] DP_ROT_MUL   = 4'd9;
  localparam logic [3:0] DP_ROT_ACC   = 4'd10;
  localparam logic [3:0] DP_COMMIT    = 4'd11;

  // Rotation product order
  localparam logic [1:0] ROT_LX_CH = 2'd0;
  localparam logic [1:0] ROT_LY_SH = 2'd1;
  localparam logic [1:0] ROT_LX_SH = 2'd2;
  localparam logic [1:0] ROT_LY_CH = 2'd3;

  typedef struct packed {
    logic [3:0] step;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic load_op;
    logic cordic_busy;
    logic div_busy;
  } dp_status_t;

  // atan(2^-i) in 2^-32 turns
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hdl/arcpi_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arcpi_cordic
// Iterative rotation-mode CORDIC: sine and cosine of a 32-bit phase, Q2.30.
// ----------------------------------------------------------------------------
module arcpi_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [31:0]        phase,
  output logic                    busy,
  output logic signed [31:0]      cos_out,
  output logic signed [31:0]      sin_out
);

  logic signed [arcpi_pkg::CORD_W-1:0] x, y, z;
  logic signed [arcpi_pkg::CORD_W-1:0] x_next, y_next, z_next;
  logic signed [arcpi_pkg::CORD_W-1:0] z_in, z_pre, dx, dy, ang;
  logic signed [arcpi_pkg::CORD_W-1:0] xf, yf, xc, yc;
  logic                                neg, neg_pre;
  logic [4:0]                          cnt;

  // fold phases beyond a quarter turn by a half turn
  always_comb begin
    z_in    = $signed({{2{phase[31]}}, phase});
    z_pre   = z_in;
    neg_pre = 1'b0;
    if (z_in > arcpi_pkg::ONE_Q30) begin
      z_pre   = z_in - arcpi_pkg::HALF_TURN;
      neg_pre = 1'b1;
    end else if (z_in < -arcpi_pkg::ONE_Q30) begin
      z_pre   = z_in + arcpi_pkg::HALF_TURN;
      neg_pre = 1'b1;
    end
  end

  always_comb begin
    dx  = y >>> cnt;
    dy  = x >>> cnt;
    ang = $signed({4'b0, arcpi_pkg::atan_entry(cnt)});
    if (z >= 0) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - ang;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'(arcpi_pkg::CORDIC_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= arcpi_pkg::CORDIC_START;
      y   <= '0;
      z   <= z_pre;
      neg <= neg_pre;
      cnt <= '0;
    end else if (busy) begin
      x   <= x_next;
      y   <= y_next;
      z   <= z_next;
      cnt <= cnt + 5'd1;
    end
  end

  // undo the fold, clamp to +/- 1.0
  always_comb begin
    xf = neg ? -x : x;
    yf = neg ? -y : y;
    xc = xf;
    yc = yf;
    if (xf > arcpi_pkg::ONE_Q30) xc = arcpi_pkg::ONE_Q30;
    if (xf < -arcpi_pkg::ONE_Q30) xc = -arcpi_pkg::ONE_Q30;
    if (yf > arcpi_pkg::ONE_Q30) yc = arcpi_pkg::ONE_Q30;
    if (yf < -arcpi_pkg::ONE_Q30) yc = -arcpi_pkg::ONE_Q30;
  end

  assign cos_out = xc[31:0];
  assign sin_out = yc[31:0];

endmodule
`default_nettype wire

>>> hdl/arcpi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arcpi_div
// Two-lane restoring divider, (num << 32) / den, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module arcpi_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num_a,
  input  wire logic [31:0] num_b,
  input  wire logic [23:0] den,
  output logic             busy,
  output logic [63:0]      quot_a,
  output logic [63:0]      quot_b
);

  logic [23:0] rem      [2];
  logic [63:0] dvd      [2];
  logic [23:0] rem_next [2];
  logic [63:0] dvd_next [2];
  logic [31:0] num      [2];
  logic [24:0] t1, t2, r1, r2;
  logic        ge1, ge2;
  logic [4:0]  cnt;

  assign num[0] = num_a;
  assign num[1] = num_b;

  // shift the dividend out the top, quotient bits in at the bottom
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t1 = {rem[l], dvd[l][63]};
      ge1 = (t1 >= {1'b0, den});
      r1 = ge1 ? (t1 - {1'b0, den}) : t1;
      t2 = {r1[23:0], dvd[l][62]};
      ge2 = (t2 >= {1'b0, den});
      r2 = ge2 ? (t2 - {1'b0, den}) : t2;
      rem_next[l] = r2[23:0];
      dvd_next[l] = {dvd[l][61:0], ge1, ge2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd31) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      for (int l = 0; l < 2; l++) begin
        rem[l] <= '0;
        dvd[l] <= {num[l], 32'b0};
      end
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      for (int l = 0; l < 2; l++) begin
        rem[l] <= rem_next[l];
        dvd[l] <= dvd_next[l];
      end
    end
  end

  assign quot_a = dvd[0];
  assign quot_b = dvd[1];

endmodule
`default_nettype wire

>>> hdl/arcpi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arcpi_datapath
// Configuration registers, pose state, turn phase, sine/cosine, curvature
// divide, rotation into the world frame and the output registers.
// ----------------------------------------------------------------------------
module arcpi_datapath #(
  parameter int ANGLE_BITS    = 16,
  parameter int POS_FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire arcpi_pkg::dp_cmd_t  cmd,
  output arcpi_pkg::dp_status_t    status,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [23:0]         cfg_data,
  input  wire logic                op,
  input  wire logic [2:0]          motion_code,
  input  wire logic signed [31:0]  load_x,
  input  wire logic signed [31:0]  load_y,
  input  wire logic [15:0]         load_heading,
  output logic signed [31:0]       pos_x,
  output logic signed [31:0]       pos_y,
  output logic [15:0]              heading
);

  localparam int SH_Q = 46 - POS_FRAC_BITS;
  localparam int SH_D = 32 - ANGLE_BITS;

  logic [23:0]             step_length, turn_curvature;
  logic                    is_load, sl_neg, sk_nz, sk_neg;
  logic                    move_d, sl_neg_d, sk_nz_d, sk_neg_d;
  logic [23:0]             mag;
  logic signed [31:0]      ld_x, ld_y;
  logic [ANGLE_BITS-1:0]   ld_h;
  logic [31:0]             lh32;
  logic [47:0]             prod_p;
  logic [53:0]             prod_hi, prod_lo;
  logic [23:0]             mul_a;
  logic [29:0]             mul_b;
  logic [53:0]             mul_p;
  logic [63:0]             phi_sum;
  logic [31:0]             phi;
  logic                    phi_en;

  logic                    cordic_start;
  logic [31:0]             cordic_phase;
  logic                    cordic_busy;
  logic signed [31:0]      cos_v, sin_v;
  logic [31:0]             s_abs, omc;
  logic signed [33:0]      omc_w;
  logic                    div_busy;
  logic [63:0]             quot_a, quot_b;
  logic                    sin_neg, straight;

  logic [64:0]             qsum_a, qsum_b, qa, qb;
  logic [32:0]             lmag_a, lmag_b;
  logic signed [33:0]      scaled, lx_new, ly_new, lx, ly;
  logic [32:0]             dsum;
  logic [ANGLE_BITS:0]     dmag, dsigned;
  logic [ANGLE_BITS-1:0]   dturn, dturn_new;

  logic signed [33:0]      rot_a;
  logic signed [31:0]      rot_b;
  logic signed [65:0]      rot_mul, rot_prod, rnd_full;
  logic signed [35:0]      rnd;
  logic signed [36:0]      acc_x, acc_y;

  logic signed [31:0]      pose_x, pose_y, px_next, py_next;
  logic [ANGLE_BITS-1:0]   pose_h, ph_next;
  logic signed [37:0]      sum_x, sum_y;
  logic [31:0]             h32;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length    <= 24'd65536;
      turn_curvature <= 24'd65536;
    end else if (cfg_write) begin
      if (cfg_index == arcpi_pkg::CFG_STEP_LENGTH) begin
        step_length <= cfg_data;
      end else begin
        turn_curvature <= cfg_data;
      end
    end
  end

  // motion decode
  always_comb begin
    move_d   = 1'b0;
    sl_neg_d = 1'b0;
    sk_nz_d  = 1'b0;
    sk_neg_d = 1'b0;
    case (motion_code)
      arcpi_pkg::MOT_FWD: begin
        move_d = 1'b1;
      end
      arcpi_pkg::MOT_FWD_LEFT: begin
        move_d  = 1'b1;
        sk_nz_d = 1'b1;
      end
      arcpi_pkg::MOT_FWD_RIGHT: begin
        move_d   = 1'b1;
        sk_nz_d  = 1'b1;
        sk_neg_d = 1'b1;
      end
      arcpi_pkg::MOT_BACK: begin
        move_d   = 1'b1;
        sl_neg_d = 1'b1;
      end
      arcpi_pkg::MOT_BACK_LEFT: begin
        move_d   = 1'b1;
        sl_neg_d = 1'b1;
        sk_nz_d  = 1'b1;
      end
      arcpi_pkg::MOT_BACK_RIGHT: begin
        move_d   = 1'b1;
        sl_neg_d = 1'b1;
        sk_nz_d  = 1'b1;
        sk_neg_d = 1'b1;
      end
      default: begin
        move_d = 1'b0;
      end
    endcase
  end

  assign lh32 = {16'b0, load_heading};

  always_ff @(posedge clk) begin
    if (cmd.step == arcpi_pkg::DP_CAPTURE) begin
      is_load <= op;
      sl_neg  <= sl_neg_d;
      sk_nz   <= sk_nz_d;
      sk_neg  <= sk_neg_d;
      mag     <= move_d ? step_length : 24'd0;
      ld_x    <= load_x;
      ld_y    <= load_y;
      ld_h    <= lh32[ANGLE_BITS-1:0];
    end
  end

  // turn phase: one 24x30 multiplier, three passes
  always_comb begin
    case (cmd.step)
      arcpi_pkg::DP_MUL_P: begin
        mul_a = mag;
        mul_b = {6'b0, turn_curvature};
      end
      arcpi_pkg::DP_MUL_HI: begin
        mul_a = prod_p[47:24];
        mul_b = arcpi_pkg::INV_TWO_PI;
      end
      default: begin
        mul_a = prod_p[23:0];
        mul_b = arcpi_pkg::INV_TWO_PI;
      end
    endcase
  end

  assign mul_p   = 54'(mul_a) * 54'(mul_b);
  assign phi_sum = {prod_hi[39:0], 24'b0} + {10'b0, prod_lo} + 64'h8000_0000;
  assign phi_en  = sk_nz && (turn_curvature != 24'd0) && (mag != 24'd0);

  always_ff @(posedge clk) begin
    case (cmd.step)
      arcpi_pkg::DP_MUL_P:  prod_p  <= mul_p[47:0];
      arcpi_pkg::DP_MUL_HI: prod_hi <= mul_p;
      arcpi_pkg::DP_MUL_LO: prod_lo <= mul_p;
      arcpi_pkg::DP_PHI:    phi     <= phi_en ? phi_sum[63:32] : 32'd0;
      default: begin
      end
    endcase
  end

  // shared CORDIC: turn phase first, then the old heading
  assign cordic_start = (cmd.step == arcpi_pkg::DP_START_PHI) ||
                        (cmd.step == arcpi_pkg::DP_STORE_PHI);
  assign cordic_phase = (cmd.step == arcpi_pkg::DP_START_PHI) ? phi :
                        {pose_h, {SH_D{1'b0}}};

  arcpi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .phase   (cordic_phase),
    .busy    (cordic_busy),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  assign s_abs = sin_v[31] ? 32'(-sin_v) : sin_v;
  assign omc_w = arcpi_pkg::ONE_Q30 - 34'(cos_v);
  assign omc   = omc_w[33] ? 32'd0 : omc_w[31:0];

  arcpi_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.step == arcpi_pkg::DP_STORE_PHI),
    .num_a  (s_abs),
    .num_b  (omc),
    .den    (turn_curvature),
    .busy   (div_busy),
    .quot_a (quot_a),
    .quot_b (quot_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.step == arcpi_pkg::DP_STORE_PHI) begin
      sin_neg  <= sin_v[31];
      straight <= (phi == 32'd0);
    end
  end

  // straight step length at the position scale
  generate
    if (POS_FRAC_BITS >= 16) begin : g_scale_up
      assign scaled = $signed(34'(mag) << (POS_FRAC_BITS - 16));
    end else begin : g_scale_dn
      assign scaled = $signed((34'(mag) + (34'd1 << (15 - POS_FRAC_BITS)))
                              >> (16 - POS_FRAC_BITS));
    end
  endgenerate

  // round the quotients, limit, apply signs
  always_comb begin
    qsum_a = {1'b0, quot_a} + (65'd1 << (SH_Q - 1));
    qsum_b = {1'b0, quot_b} + (65'd1 << (SH_Q - 1));
    qa     = qsum_a >> SH_Q;
    qb     = qsum_b >> SH_Q;
    lmag_a = (qa > {32'b0, arcpi_pkg::LOCAL_LIMIT}) ? arcpi_pkg::LOCAL_LIMIT : qa[32:0];
    lmag_b = (qb > {32'b0, arcpi_pkg::LOCAL_LIMIT}) ? arcpi_pkg::LOCAL_LIMIT : qb[32:0];
    if (straight) begin
      lx_new = sl_neg ? -scaled : scaled;
      ly_new = '0;
    end else begin
      lx_new = (sin_neg ^ sl_neg) ? -$signed({1'b0, lmag_a}) : $signed({1'b0, lmag_a});
      ly_new = sk_neg ? -$signed({1'b0, lmag_b}) : $signed({1'b0, lmag_b});
    end
    dsum    = {1'b0, phi} + (33'd1 << (SH_D - 1));
    dmag    = dsum[32:SH_D];
    dsigned = (sl_neg ^ sk_neg) ? ((ANGLE_BITS+1)'(1) << ANGLE_BITS) - dmag : dmag;
    dturn_new = straight ? '0 : dsigned[ANGLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.step == arcpi_pkg::DP_LOCAL) begin
      lx    <= lx_new;
      ly    <= ly_new;
      dturn <= dturn_new;
    end
  end

  // rotation by the old heading: one product, then one accumulate
  always_comb begin
    rot_a = ((cmd.idx == arcpi_pkg::ROT_LX_CH) || (cmd.idx == arcpi_pkg::ROT_LX_SH)) ? lx : ly;
    rot_b = ((cmd.idx == arcpi_pkg::ROT_LX_CH) || (cmd.idx == arcpi_pkg::ROT_LY_CH)) ?
            cos_v : sin_v;
  end

  assign rot_mul  = rot_a * rot_b;
  assign rnd_full = rot_prod + $signed(66'd1 << 29);
  assign rnd      = 36'(rnd_full >>> 30);

  always_ff @(posedge clk) begin
    if (cmd.step == arcpi_pkg::DP_ROT_MUL) begin
      rot_prod <= rot_mul;
    end
    if (cmd.step == arcpi_pkg::DP_ROT_ACC) begin
      case (cmd.idx)
        arcpi_pkg::ROT_LX_CH: acc_x <= 37'(rnd);
        arcpi_pkg::ROT_LY_SH: acc_x <= acc_x - 37'(rnd);
        arcpi_pkg::ROT_LX_SH: acc_y <= 37'(rnd);
        default:              acc_y <= acc_y + 37'(rnd);
      endcase
    end
  end

  // new pose
  always_comb begin
    sum_x = 38'(pose_x) + 38'(acc_x);
    sum_y = 38'(pose_y) + 38'(acc_y);
    if (is_load) begin
      px_next = ld_x;
      py_next = ld_y;
      ph_next = ld_h;
    end else begin
      if (sum_x > 38'sd2147483647) px_next = 32'sh7FFF_FFFF;
      else if (sum_x < -38'sd2147483648) px_next = 32'sh8000_0000;
      else px_next = sum_x[31:0];
      if (sum_y > 38'sd2147483647) py_next = 32'sh7FFF_FFFF;
      else if (sum_y < -38'sd2147483648) py_next = 32'sh8000_0000;
      else py_next = sum_y[31:0];
      ph_next = pose_h + dturn;
    end
    h32 = {{(32-ANGLE_BITS){1'b0}}, ph_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x <= '0;
      pose_y <= '0;
      pose_h <= '0;
    end else if (cmd.step == arcpi_pkg::DP_COMMIT) begin
      pose_x <= px_next;
      pose_y <= py_next;
      pose_h <= ph_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == arcpi_pkg::DP_COMMIT) begin
      pos_x   <= px_next;
      pos_y   <= py_next;
      heading <= h32[15:0];
    end
  end

  assign status.load_op     = op;
  assign status.cordic_busy = cordic_busy;
  assign status.div_busy    = div_busy;

endmodule
`default_nettype wire

>>> hdl/arcpi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arcpi_ctrl
// Sequencer: steps the datapath through one command and owns the handshakes.
// ----------------------------------------------------------------------------
module arcpi_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire arcpi_pkg::dp_status_t status,
  output arcpi_pkg::dp_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_P    = 4'd1;
  localparam logic [3:0] S_MUL_HI   = 4'd2;
  localparam logic [3:0] S_MUL_LO   = 4'd3;
  localparam logic [3:0] S_PHI      = 4'd4;
  localparam logic [3:0] S_START    = 4'd5;
  localparam logic [3:0] S_WAIT_PHI = 4'd6;
  localparam logic [3:0] S_WAIT_ALL = 4'd7;
  localparam logic [3:0] S_ROT      = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state, state_next;
  logic [2:0] rot_cnt;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.step   = arcpi_pkg::DP_NOP;
    cmd.idx    = rot_cnt[2:1];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step   = arcpi_pkg::DP_CAPTURE;
          state_next = status.load_op ? S_DONE : S_MUL_P;
        end
      end
      S_MUL_P: begin
        cmd.step   = arcpi_pkg::DP_MUL_P;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.step   = arcpi_pkg::DP_MUL_HI;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.step   = arcpi_pkg::DP_MUL_LO;
        state_next = S_PHI;
      end
      S_PHI: begin
        cmd.step   = arcpi_pkg::DP_PHI;
        state_next = S_START;
      end
      S_START: begin
        cmd.step   = arcpi_pkg::DP_START_PHI;
        state_next = S_WAIT_PHI;
      end
      S_WAIT_PHI: begin
        if (!status.cordic_busy) begin
          cmd.step   = arcpi_pkg::DP_STORE_PHI;
          state_next = S_WAIT_ALL;
        end
      end
      S_WAIT_ALL: begin
        if (!status.cordic_busy && !status.div_busy) begin
          cmd.step   = arcpi_pkg::DP_LOCAL;
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        cmd.step = rot_cnt[0] ? arcpi_pkg::DP_ROT_ACC : arcpi_pkg::DP_ROT_MUL;
        if (rot_cnt == 3'd7) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.step   = arcpi_pkg::DP_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rot_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // advance the product counter only inside the rotation
      if (state == S_ROT) begin
        rot_cnt <= rot_cnt + 3'd1;
      end else begin
        rot_cnt <= '0;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/arc_pose_integrator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arc_pose_integrator_core
// Planar pose integrator for unicycle arc odometry.
// ----------------------------------------------------------------------------
// Each transfer on the input channel either loads a pose (op = 1) or applies
// one motion code to the held pose; each produces exactly one transfer of the
// updated pose on the output channel. A motion command forms the turn phase
// through one shared 24x30 multiplier, starts the single iterative CORDIC and
// runs it on the turn phase (30 micro-rotations), then the two-bits-per-cycle
// divider (sin/k and (1-cos)/k in two lanes) plus the latch of the local
// step, while the same CORDIC works out the old heading's sine and cosine,
// then rotates the local step into the world frame through one 34x32
// multiplier, and commits the pose once the output channel is free. A pose
// load goes from its transfer straight to that commit. One item is worked
// on at a time; the next one is taken in the cycle after the result lands in
// the output registers, even before it is taken downstream.
// Configuration writes (index 0 step_length, index 1 turn_curvature) are
// taken at any time and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module arc_pose_integrator_core #(
  parameter int ANGLE_BITS    = 16,
  parameter int POS_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [23:0]        cfg_data,
  // command channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [2:0]         motion_code,
  input  wire logic signed [31:0] load_x,
  input  wire logic signed [31:0] load_y,
  input  wire logic [15:0]        load_heading,
  // pose channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic [15:0]             heading
);

  arcpi_pkg::dp_cmd_t    cmd;
  arcpi_pkg::dp_status_t status;

  // sequencer: owns both handshakes and steps the datapath
  arcpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: pose state, arithmetic units and the output registers
  arcpi_datapath #(
    .ANGLE_BITS    (ANGLE_BITS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .motion_code  (motion_code),
    .load_x       (load_x),
    .load_y       (load_y),
    .load_heading (load_heading),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .heading      (heading)
  );

endmodule
`default_nettype wire

>>> tb/arc_pose_integrator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pose_integrator_core_tb
// Drives pose loads and motion codes through the command channel and checks
// every pose transfer against an in-bench fixed-point arc odometry predictor.
// ----------------------------------------------------------------------------
module arc_pose_integrator_core_tb;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        h;
  } pose_t;

  localparam longint QUARTER_TURN = 64'sd1 << 30;
  localparam longint UNIT_Q30     = 64'sd1 << 30;
  localparam longint STEP_CLAMP   = 64'sd8589934591;
  localparam logic   OP_MOVE      = 1'b0;
  localparam logic   OP_LOAD      = 1'b1;
  localparam logic [2:0] MOT_UNUSED = 3'd7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_index = arcpi_pkg::CFG_STEP_LENGTH;
  logic [23:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = OP_MOVE;
  logic [2:0]         motion_code = arcpi_pkg::MOT_NONE;
  logic signed [31:0] load_x = '0;
  logic signed [31:0] load_y = '0;
  logic [15:0]        load_heading = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;

  arc_pose_integrator_core DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .motion_code(motion_code),
    .load_x(load_x), .load_y(load_y), .load_heading(load_heading),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: shadow registers and pose
  logic [23:0]        mdl_step_len = 24'd65536;
  logic [23:0]        mdl_curv     = 24'd65536;
  logic signed [31:0] mdl_x = '0;
  logic signed [31:0] mdl_y = '0;
  logic [15:0]        mdl_h = '0;

  pose_t pose_q[$];
  bit    failed = 1'b0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_cycles = 0;

  const longint arctan_turns[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // rotation-mode CORDIC on a 2^-32-turn phase, Q2.30 results
  function automatic void phase_sincos(input logic [31:0] ph, output longint c,
                                       output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed(ph));
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > QUARTER_TURN) begin
      z -= 2 * QUARTER_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z += 2 * QUARTER_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_turns[i];
      end else begin
        x += dx; y -= dy; z += arctan_turns[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clamp_mag(x, UNIT_Q30);
    s = clamp_mag(y, UNIT_Q30);
  endfunction

  // n / k rescaled to the position format, rounded half up
  function automatic longint div_by_curv(longint unsigned n, logic [23:0] k);
    longint unsigned t;
    t = (n << 32) / k;
    return longint'((t + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint rnd_q30(longint v);
    return (v + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] sat_pos(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // advance the predicted pose by one command and return the new pose
  function automatic pose_t next_pose(logic o, logic [2:0] mc, logic [31:0] lx_in,
                                      logic [31:0] ly_in, logic [15:0] lh_in);
    int sl, sk;
    longint unsigned mag, prod, ph64, dt;
    logic [31:0] phi;
    longint lx, ly, ch, sh, c, s, omc, dx, dy;
    pose_t r;
    sl = 0; sk = 0; dt = 0; phi = '0;
    if (o == OP_LOAD) begin
      mdl_x = lx_in; mdl_y = ly_in; mdl_h = lh_in;
    end else begin
      case (mc)
        arcpi_pkg::MOT_FWD:        begin sl = 1;  sk = 0;  end
        arcpi_pkg::MOT_FWD_LEFT:   begin sl = 1;  sk = 1;  end
        arcpi_pkg::MOT_FWD_RIGHT:  begin sl = 1;  sk = -1; end
        arcpi_pkg::MOT_BACK:       begin sl = -1; sk = 0;  end
        arcpi_pkg::MOT_BACK_LEFT:  begin sl = -1; sk = 1;  end
        arcpi_pkg::MOT_BACK_RIGHT: begin sl = -1; sk = -1; end
        default: ;
      endcase
      mag = (sl != 0) ? mdl_step_len : 0;
      if (sk != 0 && mdl_curv != 0 && mag != 0) begin
        prod = mag * mdl_curv;
        ph64 = prod * 64'd683565276 + (64'd1 << 31);
        phi  = ph64[63:32];
      end
      if (phi == 0) begin
        lx = longint'(mag);
        ly = 0;
      end else begin
        phase_sincos(phi, c, s);
        lx = div_by_curv((s < 0) ? -s : s, mdl_curv);
        if (s < 0) lx = -lx;
        omc = UNIT_Q30 - c;
        if (omc < 0) omc = 0;
        ly = div_by_curv(omc, mdl_curv);
        if (sk < 0) ly = -ly;
        dt = ({32'd0, phi} + (64'd1 << 15)) >> 16;
        if (sl * sk < 0) dt = 64'd65536 - dt;
        dt &= 64'hFFFF;
      end
      if (sl < 0) lx = -lx;
      lx = clamp_mag(lx, STEP_CLAMP);
      ly = clamp_mag(ly, STEP_CLAMP);
      phase_sincos({mdl_h, 16'd0}, ch, sh);
      dx = rnd_q30(lx * ch) - rnd_q30(ly * sh);
      dy = rnd_q30(lx * sh) + rnd_q30(ly * ch);
      mdl_x = sat_pos(longint'(mdl_x) + dx);
      mdl_y = sat_pos(longint'(mdl_y) + dy);
      mdl_h = mdl_h + dt[15:0];
    end
    r.x = mdl_x; r.y = mdl_y; r.h = mdl_h;
    return r;
  endfunction

  // Receiver: stall at random, hold off while hold_cycles runs down,
  // and check every pose transfer against the oldest prediction.
  always @(posedge clk) begin
    pose_t e;
    if (out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        $display("%0t: pose transfer with nothing expected: x=%0d y=%0d h=%0d",
                 $time, pos_x, pos_y, heading);
        failed = 1'b1;
      end else begin
        e = pose_q.pop_front();
        if (pos_x !== e.x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, e.x, pos_x);
          failed = 1'b1;
        end
        if (pos_y !== e.y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, e.y, pos_y);
          failed = 1'b1;
        end
        if (heading !== e.h) begin
          $display("%0t: heading expected %0d actual %0d", $time, e.h, heading);
          failed = 1'b1;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one command and wait for its transfer; the prediction is queued
  // at the accepting edge. Called right after an edge, so each step sees
  // only one assignment to in_valid.
  task automatic send_cmd(logic o, logic [2:0] mc, logic [31:0] x, logic [31:0] y,
                          logic [15:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    motion_code  <= mc;
    load_x       <= x;
    load_y       <= y;
    load_heading <= h;
    do @(posedge clk); while (!in_ready);
    pose_q.push_back(next_pose(o, mc, x, y, h));
  endtask

  task automatic send_random_cmd();
    logic o;
    o = ($urandom_range(99) < 12) ? OP_LOAD : OP_MOVE;
    send_cmd(o, 3'($urandom_range(7)), $urandom, $urandom, 16'($urandom));
  endtask

  // drop valid, wait for every pose, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == arcpi_pkg::CFG_STEP_LENGTH) mdl_step_len = val;
    else mdl_curv = val;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_reg_value();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 255));
      3: return 24'($urandom_range(16384, 262144));
      default: return 24'($urandom);
    endcase
  endfunction

  // extremes of the pose fields and every motion code at reset settings
  task automatic test_directed();
    send_cmd(OP_MOVE, arcpi_pkg::MOT_NONE, '0, '0, '0);
    for (int m = 1; m <= 6; m++) send_cmd(OP_MOVE, 3'(m), '0, '0, '0);
    send_cmd(OP_MOVE, MOT_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_cmd(OP_LOAD, arcpi_pkg::MOT_FWD, 32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_BACK_LEFT, '0, '0, '0);
    // push against both saturation limits
    send_cmd(OP_LOAD, arcpi_pkg::MOT_NONE, 32'sh7FFF0000, 32'sh7FFF8000, 16'h0000);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_FWD, '0, '0, '0);
    send_cmd(OP_LOAD, arcpi_pkg::MOT_BACK_RIGHT, 32'sh80000000, 32'sh80000001, 16'h8000);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_FWD_RIGHT, '0, '0, '0);
    send_cmd(OP_LOAD, MOT_UNUSED, 32'h55555555, 32'hAAAAAAAA, 16'h4000);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_BACK, '0, '0, '0);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_FWD_LEFT, '0, '0, '0);
    drain();
  endtask

  // zero length, zero curvature, extreme registers
  task automatic test_register_corners();
    write_reg(arcpi_pkg::CFG_STEP_LENGTH, 24'd0);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_FWD_LEFT, '0, '0, '0);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_BACK_RIGHT, '0, '0, '0);
    drain();
    write_reg(arcpi_pkg::CFG_STEP_LENGTH, 24'd65536);
    write_reg(arcpi_pkg::CFG_TURN_CURVATURE, 24'd0);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_FWD_LEFT, '0, '0, '0);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_BACK_RIGHT, '0, '0, '0);
    drain();
    // turn too small to register: straight step, heading held
    write_reg(arcpi_pkg::CFG_STEP_LENGTH, 24'd1);
    write_reg(arcpi_pkg::CFG_TURN_CURVATURE, 24'd1);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_FWD_LEFT, '0, '0, '0);
    drain();
    write_reg(arcpi_pkg::CFG_STEP_LENGTH, 24'hFFFFFF);
    write_reg(arcpi_pkg::CFG_TURN_CURVATURE, 24'hFFFFFF);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_FWD_RIGHT, '0, '0, '0);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_BACK_LEFT, '0, '0, '0);
    drain();
    // huge radius: longest step at the smallest nonzero curvature
    write_reg(arcpi_pkg::CFG_TURN_CURVATURE, 24'd1);
    send_cmd(OP_LOAD, arcpi_pkg::MOT_NONE, '0, '0, 16'h2000);
    send_cmd(OP_MOVE, arcpi_pkg::MOT_FWD_LEFT, '0, '0, '0);
    drain();
  endtask

  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(arcpi_pkg::CFG_STEP_LENGTH, pick_reg_value());
    write_reg(arcpi_pkg::CFG_TURN_CURVATURE, pick_reg_value());
    for (int i = 0; i < n; i++) send_random_cmd();
    drain();
  endtask

  // long receiver hold-off while commands keep coming, so input stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(arcpi_pkg::CFG_STEP_LENGTH, 24'd32768);
    write_reg(arcpi_pkg::CFG_TURN_CURVATURE, 24'd98304);
    hold_cycles = 600;
    for (int i = 0; i < 12; i++) send_random_cmd();
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_corners();
    test_backpressure();
    for (int p = 0; p < 2; p++) begin
      test_random_phase(70, 0, 0);
      test_random_phase(70, 55, 0);
      test_random_phase(70, 0, 55);
      test_random_phase(50, 38, 38);
    end
    if (!failed && pose_q.size() == 0) begin
      $display("arc_pose_integrator_core_tb passed");
    end else begin
      $display("arc_pose_integrator_core_tb failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("arc_pose_integrator_core_tb failed");
    $finish;
  end

endmodule
